// ===== rtl/core/utf8l1_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with Latin-1 fallback.
// No dependencies.
`timescale 1ns / 1ps

package utf8l1_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CP_W      = 16;
    localparam int unsigned MAX_RES   = 3;   // results one byte can cause
    localparam int unsigned HOLD_D    = 2;   // held bytes across requests

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CP_W-1:0]   t_cp;
    typedef logic [1:0]        t_cnt;        // 0..3 results / 0..2 held

    // byte class masks and tags
    localparam t_byte MASK_CONT = 8'hC0;
    localparam t_byte TAG_CONT  = 8'h80;
    localparam t_byte MASK_LEAD2 = 8'hE0;
    localparam t_byte TAG_LEAD2  = 8'hC0;
    localparam t_byte MASK_LEAD3 = 8'hF0;
    localparam t_byte TAG_LEAD3  = 8'hE0;
    localparam t_byte PAY_LEAD2 = 8'h1F;
    localparam t_byte PAY_LEAD3 = 8'h0F;
    localparam t_byte PAY_CONT  = 8'h3F;
    localparam t_byte ASCII_LIM = 8'h80;

    function automatic logic is_cont(input t_byte b);
        is_cont = (b & MASK_CONT) == TAG_CONT;
    endfunction

endpackage

// ===== rtl/core/utf8_decoder_latin1_fallback_core.sv =====
// UTF-8 decoder with Latin-1 fallback, top level.
// Depends on utf8l1_pkg (types, byte class constants).
`timescale 1ns / 1ps
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  input    | in        | i_valid / o_stall    | i_data_byte[7:0], i_end_of_string
//  result   | out       | o_valid / i_stall    | o_code_point[15:0], o_run_last
//
//  One request a cycle is taken while o_stall is low. Each request is decoded
//  in the cycle it is taken, against the held bytes, into a bundle of zero to
//  three results that is registered; the bundle drains one result per cycle
//  while i_stall is low. A request that causes N results occupies the result
//  register until its last result is taken, so a plain byte stream runs at one
//  byte per clock. The result register is the only thing that sets the rate.
//  Reset (synchronous, active low) empties the result register and drops any
//  held bytes. o_stall rises while the bundle still has more than one result
//  to give, or its last one is itself stalled.

module utf8_decoder_latin1_fallback_core
    import utf8l1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    // results
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_point,
    output logic        o_run_last
);

    // held bytes: a waiting lead and at most one continuation
    t_byte r_pend [HOLD_D];
    t_byte n_pend [HOLD_D];
    t_cnt  r_pcnt;
    t_cnt  n_pcnt;

    // result bundle
    t_cp   r_res  [MAX_RES];
    t_cp   n_res  [MAX_RES];
    t_cnt  r_left;            // results still to deliver
    t_cnt  r_idx;             // next result to deliver
    t_cnt  n_k;               // results produced by this request

    logic  in_acc;
    logic  out_acc;

    assign o_valid      = r_left != 2'd0;
    assign o_code_point = r_res[r_idx];
    assign o_run_last   = r_left == 2'd1;
    assign out_acc      = o_valid && !i_stall;
    // free next cycle if empty or the last result leaves now
    assign o_stall      = (r_left > 2'd1) || (r_left == 2'd1 && i_stall);
    assign in_acc       = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Decode: walk the (held + new) bytes, at most three steps.
    // ------------------------------------------------------------------
    always_comb begin
        t_byte      bufb [5];
        logic [1:0] n;
        logic [1:0] pos;
        logic [1:0] adv;
        logic [1:0] avail;
        logic       stop;
        logic       emit;
        t_cp        cp;
        t_byte      b0;
        t_byte      b1;
        t_byte      b2;
        logic [2:0] i1;
        logic [2:0] i2;

        for (int j = 0; j < 5; j++) begin
            bufb[j] = '0;
        end
        unique case (r_pcnt)
            2'd0: begin
                bufb[0] = i_data_byte;
                n       = 2'd1;
            end
            2'd1: begin
                bufb[0] = r_pend[0];
                bufb[1] = i_data_byte;
                n       = 2'd2;
            end
            default: begin
                bufb[0] = r_pend[0];
                bufb[1] = r_pend[1];
                bufb[2] = i_data_byte;
                n       = 2'd3;
            end
        endcase

        pos  = '0;
        stop = 1'b0;
        n_k  = '0;
        for (int j = 0; j < MAX_RES; j++) begin
            n_res[j] = '0;
        end

        for (int s = 0; s < MAX_RES; s++) begin
            adv   = 2'd1;
            emit  = 1'b0;
            cp    = '0;
            i1    = {1'b0, pos} + 3'd1;
            i2    = {1'b0, pos} + 3'd2;
            b0    = bufb[{1'b0, pos}];
            b1    = bufb[i1];
            b2    = bufb[i2];
            avail = n - pos;
            if (!stop && pos < n) begin
                emit = 1'b1;
                cp   = {8'h00, b0};
                if (b0 < ASCII_LIM) begin
                    adv = 2'd1;
                end else if ((b0 & MASK_LEAD2) == TAG_LEAD2) begin
                    if (avail < 2'd2) begin
                        // lead waits for its continuation unless string ends
                        if (!i_end_of_string) begin
                            emit = 1'b0;
                            stop = 1'b1;
                        end
                    end else if (is_cont(b1)) begin
                        cp  = {5'd0, b0[4:0] & PAY_LEAD2[4:0], b1[5:0] & PAY_CONT[5:0]};
                        adv = 2'd2;
                    end
                end else if ((b0 & MASK_LEAD3) == TAG_LEAD3) begin
                    if (avail < 2'd2) begin
                        if (!i_end_of_string) begin
                            emit = 1'b0;
                            stop = 1'b1;
                        end
                    end else if (!is_cont(b1)) begin
                        adv = 2'd1;
                    end else if (avail < 2'd3) begin
                        if (!i_end_of_string) begin
                            emit = 1'b0;
                            stop = 1'b1;
                        end
                    end else if (is_cont(b2)) begin
                        cp  = {b0[3:0] & PAY_LEAD3[3:0], b1[5:0] & PAY_CONT[5:0],
                               b2[5:0] & PAY_CONT[5:0]};
                        adv = 2'd3;
                    end
                end
                // stray continuation and four-byte/invalid leads: Latin-1
                if (emit) begin
                    n_res[n_k] = cp;
                    n_k        = n_k + 2'd1;
                    pos        = pos + adv;
                end
            end else begin
                stop = 1'b1;
            end
        end

        // leftover bytes become the held state
        n_pcnt    = n - pos;
        n_pend[0] = (n_pcnt != 2'd0) ? bufb[{1'b0, pos}] : '0;
        i1        = {1'b0, pos} + 3'd1;
        n_pend[1] = (n_pcnt == 2'd2) ? bufb[i1] : '0;
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt    <= '0;
            r_pend[0] <= '0;
            r_pend[1] <= '0;
            r_left    <= '0;
            r_idx     <= '0;
        end else begin
            if (in_acc) begin
                r_pcnt <= n_pcnt;
                r_pend <= n_pend;
                r_left <= n_k;
                r_idx  <= '0;
            end else if (out_acc) begin
                r_left <= r_left - 2'd1;
                r_idx  <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

endmodule
